>>> hw/rtl/ifa_pkg.sv
// ----------------------------------------------------------------------------
// ifa_pkg
// Shared types, character codes and helpers for the integer formatter.
// ----------------------------------------------------------------------------
package ifa_pkg;

    localparam int VAL_W      = 64;   // input value width
    localparam int DIG_W      = 80;   // digit shift register, holds 20 BCD digits
    localparam int BCD_DIGITS = 20;   // decimal digits of a 64-bit magnitude
    localparam int CNT_W      = 7;    // digit counts
    localparam int POS_W      = 8;    // character positions
    localparam int ITER_W     = 6;    // double-dabble bit counter

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // control from the emitter to the digit unit
    typedef struct packed {
        logic start;   // word accepted, load a new value
        logic pop;     // consume the top digit
    } dig_ctrl_t;

    // status from the digit unit to the emitter
    typedef struct packed {
        logic             done;
        logic             zero;
        logic [CNT_W-1:0] count;
        logic [3:0]       top;
    } dig_stat_t;

    // digit slots in the shift register for each radix
    function automatic logic [CNT_W-1:0] digit_slots(input radix_t r);
        logic [CNT_W-1:0] s;
        case (r)
            RADIX_BIN: s = 7'd64;
            RADIX_OCT: s = 7'd22;
            RADIX_DEC: s = 7'd20;
            RADIX_HEX: s = 7'd16;
            default:   s = 7'd16;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

>>> hw/rtl/ifa_digit_unit.sv
// ----------------------------------------------------------------------------
// ifa_digit_unit
// Magnitude, BCD conversion and digit normalization; shifts digits out MSB first.
// ----------------------------------------------------------------------------
module ifa_digit_unit
    import ifa_pkg::*;
#(
    parameter int MAX_DIGITS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dig_ctrl_t        ctrl,
    input  logic [VAL_W-1:0] value,
    input  logic [1:0]       radix_select,
    input  logic             is_signed,
    output dig_stat_t        stat
);

    localparam logic [CNT_W-1:0] MAX_DIG_L = CNT_W'(MAX_DIGITS);

    typedef enum logic [3:0] {
        D_IDLE   = 4'b0001,
        D_DABBLE = 4'b0010,
        D_NORM   = 4'b0100,
        D_DONE   = 4'b1000
    } dstate_t;

    dstate_t           dstate_reg, dstate_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              nz_drop_reg, nz_drop_next;
    logic [VAL_W-1:0]  bin_reg, bin_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    radix_t            radix_reg, radix_next;
    logic              zero_reg, zero_next;

    logic [VAL_W-1:0]  mag;
    logic [DIG_W-1:0]  bcd_adj;
    logic [DIG_W-1:0]  dig_shifted;
    logic [3:0]        top_digit;

    assign mag = (is_signed && value[VAL_W-1]) ? (~value + VAL_W'(1)) : value;

    // add-3 correction on every BCD digit, all independent
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                (dig_reg[4*i +: 4] + 4'd3) : dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        case (radix_reg)
            RADIX_BIN:
            begin
                top_digit   = {3'b000, dig_reg[DIG_W-1]};
                dig_shifted = {dig_reg[DIG_W-2:0], 1'b0};
            end
            RADIX_OCT:
            begin
                top_digit   = {1'b0, dig_reg[DIG_W-1 -: 3]};
                dig_shifted = {dig_reg[DIG_W-4:0], 3'b000};
            end
            default:
            begin
                top_digit   = dig_reg[DIG_W-1 -: 4];
                dig_shifted = {dig_reg[DIG_W-5:0], 4'b0000};
            end
        endcase
    end

    always_comb
    begin
        dstate_next  = dstate_reg;
        cnt_next     = cnt_reg;
        iter_next    = iter_reg;
        nz_drop_next = nz_drop_reg;
        bin_next     = bin_reg;
        dig_next     = dig_reg;
        radix_next   = radix_reg;
        zero_next    = zero_reg;

        if (ctrl.start)
        begin
            radix_next   = radix_t'(radix_select);
            zero_next    = (value == '0);
            iter_next    = '0;
            nz_drop_next = 1'b0;
            bin_next     = mag;
            cnt_next     = digit_slots(radix_t'(radix_select));
            case (radix_t'(radix_select))
                RADIX_DEC:
                begin
                    dig_next    = '0;
                    dstate_next = D_DABBLE;
                end
                RADIX_OCT:
                begin
                    dig_next    = {2'b00, mag, 14'd0};
                    dstate_next = D_NORM;
                end
                default:
                begin
                    dig_next    = {mag, 16'd0};
                    dstate_next = D_NORM;
                end
            endcase
        end
        else
        begin
            case (dstate_reg)
                D_IDLE:
                begin
                    dstate_next = D_IDLE;
                end
                D_DABBLE:
                begin
                    dig_next  = {bcd_adj[DIG_W-2:0], bin_reg[VAL_W-1]};
                    bin_next  = {bin_reg[VAL_W-2:0], 1'b0};
                    iter_next = iter_reg + ITER_W'(1);
                    if (iter_reg == '1)
                    begin
                        dstate_next = D_NORM;
                    end
                end
                D_NORM:
                begin
                    // drop leading zeros, and digits above the kept count;
                    // once a nonzero digit is dropped the kept zeros stay
                    if ((cnt_reg > MAX_DIG_L) ||
                        ((cnt_reg > CNT_W'(1)) && (top_digit == 4'd0) && !nz_drop_reg))
                    begin
                        dig_next     = dig_shifted;
                        cnt_next     = cnt_reg - CNT_W'(1);
                        nz_drop_next = nz_drop_reg || (top_digit != 4'd0);
                    end
                    else
                    begin
                        dstate_next = D_DONE;
                    end
                end
                D_DONE:
                begin
                    if (ctrl.pop)
                    begin
                        dig_next = dig_shifted;
                    end
                end
                default:
                begin
                    dstate_next = D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg  <= D_IDLE;
            cnt_reg     <= '0;
            iter_reg    <= '0;
            nz_drop_reg <= 1'b0;
        end
        else
        begin
            dstate_reg  <= dstate_next;
            cnt_reg     <= cnt_next;
            iter_reg    <= iter_next;
            nz_drop_reg <= nz_drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        dig_reg   <= dig_next;
        radix_reg <= radix_next;
        zero_reg  <= zero_next;
    end

    assign stat.done  = (dstate_reg == D_DONE);
    assign stat.zero  = zero_reg;
    assign stat.count = cnt_reg;
    assign stat.top   = top_digit;

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (dstate_reg == D_DONE) |-> (cnt_reg >= CNT_W'(1)) && (cnt_reg <= MAX_DIG_L))
        else $error("digit count out of range");

    a_pop_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (dstate_reg == D_DONE))
        else $error("digit popped before conversion finished");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> ((dstate_reg == D_IDLE) || (dstate_reg == D_DONE)))
        else $error("new value loaded during conversion");

endmodule

>>> hw/rtl/ifa_emitter.sv
// ----------------------------------------------------------------------------
// ifa_emitter
// Field layout and character sequencer with a registered output word.
// ----------------------------------------------------------------------------
module ifa_emitter
    import ifa_pkg::*;
#(
    parameter int MAX_CHARS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                value_msb,
    input  logic [1:0]          radix_select,
    input  logic                is_signed,
    input  logic                show_plus,
    input  logic                space_sign,
    input  logic                left_justify,
    input  logic                zero_pad,
    input  logic                alt_prefix,
    input  logic                lower_case,
    input  logic signed [6:0]   min_width,
    input  logic signed [6:0]   digit_precision,
    input  dig_stat_t           dstat,
    output dig_ctrl_t           dctrl,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char,
    output logic                last_char,
    output logic                clipped
);

    localparam logic [POS_W-1:0] MAX_CHARS_P = POS_W'(MAX_CHARS);

    typedef enum logic [4:0] {
        E_IDLE  = 5'b00001,
        E_WAIT  = 5'b00010,
        E_CALC  = 5'b00100,
        E_BOUND = 5'b01000,
        E_EMIT  = 5'b10000
    } estate_t;

    estate_t            estate_reg, estate_next;

    // captured item flags
    logic [7:0]         sign_ch_reg, sign_ch_next;
    logic               sign_en_reg, sign_en_next;
    logic               alt_reg, alt_next;
    radix_t             radix_reg, radix_next;
    logic               zpad_reg, zpad_next;
    logic               left_reg, left_next;
    logic [7:0]         lc_reg, lc_next;
    logic signed [6:0]  width_reg, width_next;
    logic signed [6:0]  prec_reg, prec_next;

    // layout
    logic [CNT_W-1:0]   prec_eff_reg, prec_eff_next;
    logic [6:0]         pad_reg, pad_next;
    logic [POS_W-1:0]   body_reg, body_next;
    logic [POS_W-1:0]   e0_reg, e0_next;
    logic [POS_W-1:0]   e1_reg, e1_next;
    logic [POS_W-1:0]   e2_reg, e2_next;
    logic [POS_W-1:0]   e3_reg, e3_next;
    logic [POS_W-1:0]   e4_reg, e4_next;
    logic [POS_W-1:0]   last_idx_reg, last_idx_next;
    logic               clip_run_reg, clip_run_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    // output word
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               last_reg, last_next;
    logic               clip_reg, clip_next;

    logic               accept;
    logic               can_load;
    logic [1:0]         pfx_len;
    logic               prec_gt;
    logic [CNT_W-1:0]   prec_eff;
    logic [POS_W-1:0]   body;
    logic signed [8:0]  width_s9;
    logic signed [8:0]  body_s9;
    logic signed [8:0]  pad_s9;
    logic [POS_W-1:0]   pad_p;
    logic [POS_W-1:0]   lead;
    logic [POS_W-1:0]   zfill;
    logic [POS_W-1:0]   tot;
    logic               tot_clip;
    logic [POS_W-1:0]   e2_calc;
    logic [POS_W-1:0]   e4_calc;
    logic               in_digits;
    logic               is_last;
    logic [7:0]         ch;

    assign in_ready = (estate_reg == E_IDLE);
    assign accept   = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;

    // prefix length: two for 0x/0b, one for octal 0 on a nonzero value
    always_comb
    begin
        if (!alt_reg)
        begin
            pfx_len = 2'd0;
        end
        else if (radix_reg == RADIX_OCT)
        begin
            pfx_len = dstat.zero ? 2'd0 : 2'd1;
        end
        else
        begin
            pfx_len = 2'd2;
        end
    end

    // width bookkeeping
    assign prec_gt  = $signed({prec_reg[6], prec_reg}) > $signed({1'b0, dstat.count});
    assign prec_eff = prec_gt ? CNT_W'(prec_reg) : dstat.count;
    assign body     = POS_W'(sign_en_reg) + POS_W'(pfx_len) + POS_W'(prec_eff);
    assign width_s9 = {{2{width_reg[6]}}, width_reg};
    assign body_s9  = $signed({1'b0, body});
    assign pad_s9   = width_s9 - body_s9;

    // run boundaries
    assign pad_p    = POS_W'(pad_reg);
    assign lead     = (!zpad_reg && !left_reg) ? pad_p : '0;
    assign zfill    = zpad_reg ? pad_p : '0;
    assign e2_calc  = lead + POS_W'(sign_en_reg) + POS_W'(pfx_len);
    assign e4_calc  = e2_calc + zfill + POS_W'(prec_eff_reg);
    assign tot      = pad_p + body_reg;
    assign tot_clip = tot > MAX_CHARS_P;

    // character at the current position
    assign in_digits = (pos_reg >= e3_reg) && (pos_reg < e4_reg);
    assign is_last   = (pos_reg == last_idx_reg);

    always_comb
    begin
        if (pos_reg < e0_reg)
        begin
            ch = CH_SPACE;
        end
        else if (pos_reg < e1_reg)
        begin
            ch = sign_ch_reg;
        end
        else if (pos_reg < e2_reg)
        begin
            if (pos_reg == e1_reg)
            begin
                ch = CH_ZERO;
            end
            else
            begin
                ch = ((radix_reg == RADIX_HEX) ? CH_X : CH_B) | lc_reg;
            end
        end
        else if (pos_reg < e3_reg)
        begin
            ch = CH_ZERO;
        end
        else if (in_digits)
        begin
            ch = digit_char(dstat.top) | lc_reg;
        end
        else
        begin
            ch = CH_SPACE;
        end
    end

    assign dctrl.start = accept;
    assign dctrl.pop   = (estate_reg == E_EMIT) && can_load && in_digits;

    always_comb
    begin
        estate_next    = estate_reg;
        sign_ch_next   = sign_ch_reg;
        sign_en_next   = sign_en_reg;
        alt_next       = alt_reg;
        radix_next     = radix_reg;
        zpad_next      = zpad_reg;
        left_next      = left_reg;
        lc_next        = lc_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        prec_eff_next  = prec_eff_reg;
        pad_next       = pad_reg;
        body_next      = body_reg;
        e0_next        = e0_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        e3_next        = e3_reg;
        e4_next        = e4_reg;
        last_idx_next  = last_idx_reg;
        clip_run_next  = clip_run_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        clip_next      = clip_reg;

        case (estate_reg)
            E_IDLE:
            begin
                if (accept)
                begin
                    sign_en_next = is_signed && (value_msb || show_plus || space_sign);
                    if (value_msb)
                    begin
                        sign_ch_next = CH_MINUS;
                    end
                    else if (show_plus)
                    begin
                        sign_ch_next = CH_PLUS;
                    end
                    else
                    begin
                        sign_ch_next = CH_SPACE;
                    end
                    radix_next  = radix_t'(radix_select);
                    alt_next    = alt_prefix && (radix_t'(radix_select) != RADIX_DEC);
                    left_next   = left_justify;
                    zpad_next   = zero_pad && !left_justify;
                    lc_next     = lower_case ? CASE_BIT : 8'h00;
                    width_next  = min_width;
                    prec_next   = digit_precision;
                    estate_next = E_WAIT;
                end
            end
            E_WAIT:
            begin
                if (dstat.done)
                begin
                    estate_next = E_CALC;
                end
            end
            E_CALC:
            begin
                prec_eff_next = prec_eff;
                body_next     = body;
                pad_next      = (pad_s9 > 9'sd0) ? pad_s9[6:0] : 7'd0;
                estate_next   = E_BOUND;
            end
            E_BOUND:
            begin
                e0_next       = lead;
                e1_next       = lead + POS_W'(sign_en_reg);
                e2_next       = e2_calc;
                e3_next       = e4_calc - POS_W'(dstat.count);
                e4_next       = e4_calc;
                clip_run_next = tot_clip;
                last_idx_next = tot_clip ? (MAX_CHARS_P - POS_W'(1)) : (tot - POS_W'(1));
                pos_next      = '0;
                estate_next   = E_EMIT;
            end
            E_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ch;
                    last_next      = is_last;
                    clip_next      = is_last && clip_run_reg;
                    pos_next       = pos_reg + POS_W'(1);
                    if (is_last)
                    begin
                        estate_next = E_IDLE;
                    end
                end
            end
            default:
            begin
                estate_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estate_reg    <= E_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            estate_reg    <= estate_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_ch_reg  <= sign_ch_next;
        sign_en_reg  <= sign_en_next;
        alt_reg      <= alt_next;
        radix_reg    <= radix_next;
        zpad_reg     <= zpad_next;
        left_reg     <= left_next;
        lc_reg       <= lc_next;
        width_reg    <= width_next;
        prec_reg     <= prec_next;
        prec_eff_reg <= prec_eff_next;
        pad_reg      <= pad_next;
        body_reg     <= body_next;
        e0_reg       <= e0_next;
        e1_reg       <= e1_next;
        e2_reg       <= e2_next;
        e3_reg       <= e3_next;
        e4_reg       <= e4_next;
        last_idx_reg <= last_idx_next;
        clip_run_reg <= clip_run_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        clip_reg     <= clip_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;
    assign clipped   = clip_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted twice without finishing a run");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (estate_reg == E_EMIT) |-> (pos_reg <= last_idx_reg))
        else $error("emit position past end of run");

    a_clip_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clip_reg) |-> last_reg)
        else $error("clipped flag on a word that is not the last");

endmodule

>>> hw/rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer conversion of a 64-bit value, one character per word.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+-----------------------
//  in      | in_valid / in_ready              | to block  | value + format spec
//  out     | out_valid / out_ready            | from block| out_char, last_char,
//          |                                  |           | clipped
//
//  Per word in: accept; for decimal only, one BCD shift per cycle, one per input
//  bit; normalization, which drops leading digits one at a time (at most S-1,
//  then a final check; S = 64 bin, 22 oct, 20 dec, 16 hex); a wait for the
//  digit unit; the layout states CALC and BOUND; then the output characters
//  (at most MAX_CHARS). The shared digit shift register sets the conversion time.
//  in_ready is high only while no run is in progress; the last character may
//  still sit in the output register when the next word is taken.
//  Output stalls hold the sequencer; nothing is dropped. Reset is async low.
//
module integer_to_ascii_formatter
    import ifa_pkg::*;
#(
    parameter int MAX_CHARS  = 64,   // 16..64, characters kept per run
    parameter int MAX_DIGITS = 64    // 20..66, digits kept per value
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VAL_W-1:0]   value,
    input  logic [1:0]         radix_select,
    input  logic               is_signed,
    input  logic               show_plus,
    input  logic               space_sign,
    input  logic               left_justify,
    input  logic               zero_pad,
    input  logic               alt_prefix,
    input  logic               lower_case,
    input  logic signed [6:0]  min_width,
    input  logic signed [6:0]  digit_precision,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               last_char,
    output logic               clipped
);

    dig_ctrl_t dctrl;   // start / pop toward the digit unit
    dig_stat_t dstat;   // done, zero flag, digit count and current top digit

    // Digit unit: takes the magnitude, converts to BCD for decimal, strips
    // leading zeros and any digits above MAX_DIGITS, then hands out one digit per pop, MSB first.
    ifa_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digits (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (dctrl),
        .value        (value),
        .radix_select (radix_select),
        .is_signed    (is_signed),
        .stat         (dstat)
    );

    // Emitter: captures flags, works out padding/sign/prefix bounds once the
    // digit count is known, then emits one character per cycle unless stalled.
    ifa_emitter #(
        .MAX_CHARS (MAX_CHARS)
    ) u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value_msb       (value[VAL_W-1]),
        .radix_select    (radix_select),
        .is_signed       (is_signed),
        .show_plus       (show_plus),
        .space_sign      (space_sign),
        .left_justify    (left_justify),
        .zero_pad        (zero_pad),
        .alt_prefix      (alt_prefix),
        .lower_case      (lower_case),
        .min_width       (min_width),
        .digit_precision (digit_precision),
        .dstat           (dstat),
        .dctrl           (dctrl),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_char        (out_char),
        .last_char       (last_char),
        .clipped         (clipped)
    );

endmodule
